[rtl/core/bat_pkg.sv]
package bat_pkg;

    localparam int COORD_WIDTH    = 19;
    localparam int MAG_WIDTH      = COORD_WIDTH;
    localparam int REM_WIDTH      = COORD_WIDTH + 1;
    localparam int QUOT_WIDTH     = 14;
    localparam int ANGLE_WIDTH    = 8;
    localparam int IDX_WIDTH      = 6;
    localparam int TAB_LAST       = 32;
    localparam int SEARCH_STEPS   = 6;
    localparam int DIV_CNT_WIDTH  = 4;
    localparam int SRCH_CNT_WIDTH = 3;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [MAG_WIDTH-1:0]          mag_t;
    typedef logic [QUOT_WIDTH-1:0]         quot_t;
    typedef logic [ANGLE_WIDTH-1:0]        angle_t;
    typedef logic [IDX_WIDTH-1:0]          idx_t;

    localparam angle_t ANG_ZERO    = 8'h00;
    localparam angle_t ANG_QUARTER = 8'h40;
    localparam angle_t ANG_HALF    = 8'h80;
    localparam angle_t ANG_3QUART  = 8'hC0;

    // Octant placement: the table index is added to or subtracted from base.
    typedef struct packed {
        angle_t base;
        logic   sub;
    } fold_t;

    function automatic quot_t tan_entry(input idx_t idx);
        quot_t val;
        unique case (idx)
            6'd0:    val = 14'h0000;
            6'd1:    val = 14'h00C9;
            6'd2:    val = 14'h0192;
            6'd3:    val = 14'h025C;
            6'd4:    val = 14'h0326;
            6'd5:    val = 14'h03F2;
            6'd6:    val = 14'h04BF;
            6'd7:    val = 14'h058D;
            6'd8:    val = 14'h065D;
            6'd9:    val = 14'h072F;
            6'd10:   val = 14'h0803;
            6'd11:   val = 14'h08DB;
            6'd12:   val = 14'h09B5;
            6'd13:   val = 14'h0A92;
            6'd14:   val = 14'h0B73;
            6'd15:   val = 14'h0C58;
            6'd16:   val = 14'h0D41;
            6'd17:   val = 14'h0E2F;
            6'd18:   val = 14'h0F22;
            6'd19:   val = 14'h101B;
            6'd20:   val = 14'h111A;
            6'd21:   val = 14'h1220;
            6'd22:   val = 14'h132E;
            6'd23:   val = 14'h1443;
            6'd24:   val = 14'h1561;
            6'd25:   val = 14'h1689;
            6'd26:   val = 14'h17BB;
            6'd27:   val = 14'h18F9;
            6'd28:   val = 14'h1A43;
            6'd29:   val = 14'h1B9A;
            6'd30:   val = 14'h1D00;
            6'd31:   val = 14'h1E77;
            default: val = 14'h2000;
        endcase
        return val;
    endfunction

    // Signs are those of the original components; the vector is negated, so a
    // negative input component is a positive negated one.
    function automatic fold_t octant_fold(input logic x_neg, input logic y_neg,
                                          input logic gt);
        fold_t f;
        if (x_neg && y_neg) begin
            f.base = gt ? ANG_ZERO : ANG_QUARTER;
            f.sub  = !gt;
        end else if (x_neg) begin
            f.base = gt ? ANG_ZERO : ANG_3QUART;
            f.sub  = gt;
        end else if (y_neg) begin
            f.base = gt ? ANG_HALF : ANG_QUARTER;
            f.sub  = gt;
        end else begin
            f.base = gt ? ANG_HALF : ANG_3QUART;
            f.sub  = !gt;
        end
        return f;
    endfunction

endpackage

[rtl/core/bat_if.sv]
interface bat_vec_if;
    logic                 valid;
    logic                 ready;
    bat_pkg::coord_t      x_coord;
    bat_pkg::coord_t      y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface bat_res_if;
    logic                 valid;
    logic                 ready;
    bat_pkg::angle_t      angle;
    logic                 zero_vector;

    modport source (output valid, output angle, output zero_vector, input ready);
    modport sink   (input valid, input angle, input zero_vector, output ready);
endinterface

[rtl/core/bat_div.sv]
module bat_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  bat_pkg::mag_t      num,
    input  bat_pkg::mag_t      den,
    output logic               done,
    output bat_pkg::quot_t     quot
);

    localparam logic [bat_pkg::DIV_CNT_WIDTH-1:0] LAST_STEP =
        bat_pkg::DIV_CNT_WIDTH'(bat_pkg::QUOT_WIDTH - 1);

    logic [bat_pkg::REM_WIDTH-1:0]     rem_reg, rem_next;
    bat_pkg::mag_t                     den_reg;
    bat_pkg::quot_t                    quot_reg, quot_next;
    logic [bat_pkg::DIV_CNT_WIDTH-1:0] cnt_reg;
    logic                              busy_reg;
    logic                              done_reg;
    logic                              rem_ge;
    logic [bat_pkg::REM_WIDTH-1:0]     rem_sub;

    // Restoring step: the remainder stays below twice the divisor, so one
    // compare and subtract per quotient bit.
    always_comb
    begin
        rem_ge    = rem_reg >= {1'b0, den_reg};
        rem_sub   = rem_ge ? (rem_reg - {1'b0, den_reg}) : rem_reg;
        rem_next  = {rem_sub[bat_pkg::MAG_WIDTH-1:0], 1'b0};
        quot_next = {quot_reg[bat_pkg::QUOT_WIDTH-2:0], rem_ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= {1'b0, num};
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

[rtl/core/bat_search.sv]
module bat_search (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  bat_pkg::quot_t     quot,
    output logic               done,
    output bat_pkg::idx_t      idx
);

    localparam logic [bat_pkg::SRCH_CNT_WIDTH-1:0] LAST_STEP =
        bat_pkg::SRCH_CNT_WIDTH'(bat_pkg::SEARCH_STEPS - 1);
    localparam bat_pkg::idx_t TOP_IDX = bat_pkg::IDX_WIDTH'(bat_pkg::TAB_LAST);

    bat_pkg::idx_t                      lo_reg, hi_reg;
    bat_pkg::quot_t                     quot_reg;
    logic [bat_pkg::SRCH_CNT_WIDTH-1:0] cnt_reg;
    logic                               busy_reg;
    logic                               done_reg;
    logic [bat_pkg::IDX_WIDTH:0]        mid_sum;
    bat_pkg::idx_t                      mid;
    logic                               hit;

    // Binary search for the first entry not below the ratio. Once the bounds
    // meet, further steps leave them unchanged.
    always_comb
    begin
        mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
        mid     = mid_sum[bat_pkg::IDX_WIDTH:1];
        hit     = quot_reg <= bat_pkg::tan_entry(mid);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_reg   <= '0;
            hi_reg   <= TOP_IDX;
            quot_reg <= quot;
        end
        else if (busy_reg)
        begin
            if (hit)
            begin
                hi_reg <= mid;
            end
            else
            begin
                lo_reg <= mid + 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign idx  = lo_reg;

endmodule

[rtl/core/binary_angle_arctangent.sv]
// Channel  | Role   | Payload
// ---------+--------+-----------------------------------------
// operand  | sink   | x_coord, y_coord (signed, COORD_WIDTH)
// result   | source | angle (8 bits), zero_vector (1 bit)
//
// A vector's result goes through 14 divider steps, the start of the table
// search, 6 search steps, the capture of the index and the load of the output
// register. A new vector is taken only once its result is loaded; a zero
// vector skips both units.
// Reset is asynchronous and clears all control state. A result stalled in the
// output register holds the sequencer only in its last step.
module binary_angle_arctangent (
    input  logic      clk,
    input  logic      rst_n,
    bat_vec_if.sink   operand,
    bat_res_if.source result
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_SEARCH,
        S_DONE
    } state_t;

    state_t               state_reg;
    bat_pkg::fold_t       fold_reg;
    logic                 zero_reg;
    bat_pkg::idx_t        idx_reg;
    logic                 out_valid_reg;
    bat_pkg::angle_t      angle_reg;
    logic                 out_zero_reg;

    logic                 accept;
    logic                 x_neg, y_neg, gt, is_zero;
    bat_pkg::mag_t        x_mag, y_mag, num, den;
    logic                 div_start, div_done;
    bat_pkg::quot_t       quot;
    logic                 srch_start, srch_done;
    bat_pkg::idx_t        idx;
    logic                 out_free;
    logic                 out_load;
    bat_pkg::angle_t      idx_ext;
    bat_pkg::angle_t      angle_calc;

    always_comb
    begin
        x_neg   = operand.x_coord[bat_pkg::COORD_WIDTH-1];
        y_neg   = operand.y_coord[bat_pkg::COORD_WIDTH-1];
        x_mag   = x_neg ? (~operand.x_coord + 1'b1) : operand.x_coord;
        y_mag   = y_neg ? (~operand.y_coord + 1'b1) : operand.y_coord;
        is_zero = (operand.x_coord == '0) && (operand.y_coord == '0);
        // In every octant the strict test reduces to comparing magnitudes.
        gt      = x_mag > y_mag;
        num     = gt ? y_mag : x_mag;
        den     = gt ? x_mag : y_mag;
    end

    assign operand.ready = (state_reg == S_IDLE);
    assign accept        = operand.valid && operand.ready;
    assign div_start     = accept && !is_zero;
    assign srch_start    = (state_reg == S_DIV) && div_done;
    assign out_free      = !out_valid_reg || result.ready;
    assign out_load      = (state_reg == S_DONE) && out_free;

    always_comb
    begin
        idx_ext = {{(bat_pkg::ANGLE_WIDTH - bat_pkg::IDX_WIDTH){1'b0}}, idx_reg};
        if (zero_reg)
        begin
            angle_calc = bat_pkg::ANG_ZERO;
        end
        else if (fold_reg.sub)
        begin
            angle_calc = fold_reg.base - idx_ext;
        end
        else
        begin
            angle_calc = fold_reg.base + idx_ext;
        end
    end

    bat_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (den),
        .done  (div_done),
        .quot  (quot)
    );

    bat_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .start (srch_start),
        .quot  (quot),
        .done  (srch_done),
        .idx   (idx)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= is_zero ? S_DONE : S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (srch_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fold_reg <= bat_pkg::octant_fold(x_neg, y_neg, gt);
            zero_reg <= is_zero;
            idx_reg  <= '0;
        end
        else if ((state_reg == S_SEARCH) && srch_done)
        begin
            idx_reg <= idx;
        end
        if (out_load)
        begin
            angle_reg    <= angle_calc;
            out_zero_reg <= zero_reg;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.angle       = angle_reg;
    assign result.zero_vector = out_zero_reg;

endmodule

[rtl/core/bat_check.sv]
module bat_check (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            in_ready,
    input  logic            out_valid,
    input  logic            out_ready,
    input  bat_pkg::angle_t out_angle,
    input  logic            out_zero
);

    // The block works on one vector at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request taken while a vector is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_zero) |-> (out_angle == bat_pkg::ANG_ZERO))
        else $error("zero vector reported with a nonzero angle");

    // A new result is only loaded from the busy phase of the sequencer.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a vector in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(out_angle) && $stable(out_zero)))
        else $error("stalled result changed");

endmodule

bind binary_angle_arctangent bat_check u_bat_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (operand.valid),
    .in_ready  (operand.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_angle (result.angle),
    .out_zero  (result.zero_vector)
);

[test/testbench.sv]
module testbench;

    typedef struct {
        bat_pkg::coord_t x;
        bat_pkg::coord_t y;
    } vector_t;

    typedef struct {
        bat_pkg::angle_t angle;
        logic            zero_vector;
    } direction_t;

    // Tangent of k/256 of a turn, k = 0..32, scaled by 0x2000.
    localparam logic [0:32][13:0] TANGENT_STEPS = {
        14'h0000, 14'h00C9, 14'h0192, 14'h025C, 14'h0326, 14'h03F2, 14'h04BF, 14'h058D,
        14'h065D, 14'h072F, 14'h0803, 14'h08DB, 14'h09B5, 14'h0A92, 14'h0B73, 14'h0C58,
        14'h0D41, 14'h0E2F, 14'h0F22, 14'h101B, 14'h111A, 14'h1220, 14'h132E, 14'h1443,
        14'h1561, 14'h1689, 14'h17BB, 14'h18F9, 14'h1A43, 14'h1B9A, 14'h1D00, 14'h1E77,
        14'h2000
    };

    localparam int CYCLE_LIMIT   = 400000;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 40;
    localparam int RANDOM_PHASE  = 100;
    localparam int PRESSURE_SIZE = 40;
    localparam int MAX_REPORTS   = 30;

    logic clk;
    logic rst_n;

    bat_vec_if operand();
    bat_res_if result();

    binary_angle_arctangent DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand),
        .result  (result)
    );

    vector_t    pending_vectors[$];
    direction_t expected_directions[$];
    vector_t    next_vector;
    direction_t oldest_direction;

    int  send_idle_pct  = 0;
    int  recv_stall_pct = 0;
    logic hold_results  = 1'b0;
    logic hold_request  = 1'b0;
    int  error_count    = 0;
    int  sent_count     = 0;
    int  checked_count  = 0;
    int  zero_count     = 0;
    int  cycle_count    = 0;

    function automatic direction_t predict_direction(input bat_pkg::coord_t x,
                                                     input bat_pkg::coord_t y);
        direction_t d;
        longint nx;
        longint ny;
        longint num;
        longint den;
        longint ratio;
        int base;
        int idx;
        logic sub;
        d.angle = '0;
        d.zero_vector = 1'b0;
        nx = -longint'(x);
        ny = -longint'(y);
        if (nx == 0 && ny == 0) begin
            d.zero_vector = 1'b1;
            return d;
        end
        if (nx > 0) begin
            if (ny > 0) begin
                if (nx > ny) begin
                    num = ny;  den = nx;  base = 'h00;  sub = 1'b0;
                end else begin
                    num = nx;  den = ny;  base = 'h40;  sub = 1'b1;
                end
            end else begin
                if (nx > -ny) begin
                    num = -ny; den = nx;  base = 'h100; sub = 1'b1;
                end else begin
                    num = nx;  den = -ny; base = 'hC0;  sub = 1'b0;
                end
            end
        end else begin
            if (ny > 0) begin
                if (-nx > ny) begin
                    num = ny;  den = -nx; base = 'h80;  sub = 1'b1;
                end else begin
                    num = -nx; den = ny;  base = 'h40;  sub = 1'b0;
                end
            end else begin
                if (-nx > -ny) begin
                    num = -ny; den = -nx; base = 'h80;  sub = 1'b0;
                end else begin
                    num = -nx; den = -ny; base = 'hC0;  sub = 1'b1;
                end
            end
        end
        ratio = (num * 'h2000) / den;
        idx = 0;
        while (idx < 32 && ratio > longint'(TANGENT_STEPS[idx]))
            idx++;
        d.angle = bat_pkg::angle_t'(sub ? base - idx : base + idx);
        return d;
    endfunction

    function automatic bat_pkg::coord_t random_coord();
        int v;
        case ($urandom_range(3))
            0: v = int'($urandom());
            1: v = int'($urandom_range(16)) - 8;
            2: v = $urandom_range(1) ? -262144 + int'($urandom_range(7))
                                     : 262143 - int'($urandom_range(7));
            default: v = int'($urandom_range(2047)) - 1024;
        endcase
        return bat_pkg::coord_t'(v);
    endfunction

    task automatic add_vector(input int x, input int y);
        vector_t v;
        v.x = bat_pkg::coord_t'(x);
        v.y = bat_pkg::coord_t'(y);
        pending_vectors.push_back(v);
    endtask

    task automatic add_random_vectors(input int count);
        vector_t v;
        int delta;
        repeat (count) begin
            v.x = random_coord();
            v.y = random_coord();
            delta = int'($urandom_range(4)) - 2;
            case ($urandom_range(9))
                // Near the diagonals, where the tie rule decides the octant.
                6: v.y = bat_pkg::coord_t'(int'(v.x) + delta);
                7: v.y = bat_pkg::coord_t'(-int'(v.x) + delta);
                // Near the axes, where the index is small or the angle wraps.
                8: v.y = bat_pkg::coord_t'(delta);
                9: v.x = bat_pkg::coord_t'(delta);
                default: ;
            endcase
            pending_vectors.push_back(v);
        end
    endtask

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic wait_drained();
        while (pending_vectors.size() != 0 || operand.valid
               || expected_directions.size() != 0)
            @(negedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("run stopped after %0d cycles with %0d results outstanding",
                     cycle_count, expected_directions.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Request side: an offered vector is held until it is taken.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            operand.valid   <= 1'b0;
            operand.x_coord <= '0;
            operand.y_coord <= '0;
        end else begin
            if (operand.valid && operand.ready) begin
                expected_directions.push_back(
                    predict_direction(operand.x_coord, operand.y_coord));
                sent_count++;
            end
            if (!operand.valid || operand.ready) begin
                if (pending_vectors.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_vector = pending_vectors.pop_front();
                    operand.valid   <= 1'b1;
                    operand.x_coord <= next_vector.x;
                    operand.y_coord <= next_vector.y;
                end else begin
                    operand.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
            result.ready <= !hold_results && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk) begin
        if (rst_n && result.valid && result.ready) begin
            if (expected_directions.size() == 0) begin
                report_mismatch($sformatf("angle %0d arrived with no request outstanding",
                                          result.angle));
            end else begin
                oldest_direction = expected_directions.pop_front();
                if (result.angle !== oldest_direction.angle)
                    report_mismatch($sformatf("angle got %0d, expected %0d",
                                              result.angle, oldest_direction.angle));
                if (result.zero_vector !== oldest_direction.zero_vector)
                    report_mismatch($sformatf("zero_vector got %b, expected %b",
                                              result.zero_vector,
                                              oldest_direction.zero_vector));
                checked_count++;
                if (oldest_direction.zero_vector)
                    zero_count++;
            end
        end
    end

    // Long stall of the result side so the block backs up into its input.
    initial begin
        wait (hold_request);
        @(negedge clk);
        hold_results = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_results = 1'b0;
    end

    initial begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: zero vector, extremes, axes, ties, the wrap to angle zero
        // and a ratio landing exactly on a table entry.
        add_vector(0, 0);
        add_vector(-1, 0);
        add_vector(1, 0);
        add_vector(0, 1);
        add_vector(0, -1);
        add_vector(-262144, -262144);
        add_vector(262143, 262143);
        add_vector(-262144, 262143);
        add_vector(262143, -262144);
        add_vector(-262144, 0);
        add_vector(0, -262144);
        add_vector(-262143, 1);
        add_vector(5, 5);
        add_vector(-5, 5);
        add_vector(5, -5);
        add_vector(-5, -5);
        add_vector(-8192, -201);
        add_vector(-8192, -202);
        add_vector(-3, -1);
        add_vector(-1, -3);
        add_vector(3, -1);
        add_vector(1, -3);
        add_vector(-3, 1);
        add_vector(-1, 3);
        add_vector(3, 1);
        add_vector(1, 3);
        wait_drained();

        add_random_vectors(RANDOM_PHASE);
        wait_drained();

        send_idle_pct = 53;
        add_random_vectors(RANDOM_PHASE);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 53;
        add_random_vectors(RANDOM_PHASE);
        wait_drained();

        send_idle_pct  = 17;
        recv_stall_pct = 17;
        add_random_vectors(RANDOM_PHASE);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        add_random_vectors(PRESSURE_SIZE);
        hold_request = 1'b1;
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("%0d vectors sent, %0d angles checked, %0d of them zero vectors,",
                 sent_count, checked_count, zero_count);
        $display({"over free-running, sparse-request, stalled-result and mixed phases ",
                  "and one long result hold-off"});
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("%0d mismatches", error_count);
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/bat_pkg.sv
rtl/core/bat_if.sv
rtl/core/bat_div.sv
rtl/core/bat_search.sv
rtl/core/binary_angle_arctangent.sv
rtl/core/bat_check.sv
test/testbench.sv
